>>> hw/rtl/pbp_pkg.sv
`timescale 1ns / 1ps

package pbp_pkg;

   // Fixed widths of the history and sum fields, the kept magnitude and the threshold.
   localparam int HIST_W   = 16;
   localparam int DOT_W    = 13;
   localparam int MAG_W    = 12;
   localparam int THRESH_W = 12;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd44;
   localparam logic [MAG_W-1:0]    MAG_MAX      = {MAG_W{1'b1}};

   // Defaults for the top-level parameters.
   localparam int HIST_LEN_DEFAULT    = 16;
   localparam int WEIGHT_BITS_DEFAULT = 8;

   typedef enum logic [0:0] {
      FUNC_PREDICT = 1'b0,
      FUNC_TRAIN   = 1'b1
   } func_type;

   // Training command handed to the weight store.
   typedef struct packed {
      logic enable;
      logic actual_taken;
   } train_ctl_type;

endpackage

>>> hw/rtl/pbp_req_if.sv
`timescale 1ns / 1ps

interface pbp_req_if
   import pbp_pkg::*;
();
   logic                valid;
   logic                ready;
   func_type            func;
   logic [HIST_W-1:0]   history;
   logic                predicted_taken;
   logic                actual_taken;

   modport source (
      output valid, func, history, predicted_taken, actual_taken,
      input  ready
   );

   modport sink (
      input  valid, func, history, predicted_taken, actual_taken,
      output ready
   );
endinterface

>>> hw/rtl/pbp_rsp_if.sv
`timescale 1ns / 1ps

interface pbp_rsp_if
   import pbp_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     predict_taken;
   logic signed [DOT_W-1:0]  dot_sum;
   logic                     trained;

   modport source (
      output valid, predict_taken, dot_sum, trained,
      input  ready
   );

   modport sink (
      input  valid, predict_taken, dot_sum, trained,
      output ready
   );
endinterface

>>> hw/rtl/pbp_dot_tree.sv
`timescale 1ns / 1ps

module pbp_dot_tree
   import pbp_pkg::*;
#(
   parameter int HIST_LEN    = HIST_LEN_DEFAULT,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEFAULT,
   parameter int SUM_W       = WEIGHT_BITS + $clog2(HIST_LEN + 2)
) (
   input  logic [HIST_LEN:0][WEIGHT_BITS-1:0] weights,
   input  logic [HIST_LEN-1:0]                hist_bits,
   output logic signed [SUM_W-1:0]            sum
);

   localparam int NUM_TERMS = HIST_LEN + 1;
   localparam int LEVELS    = $clog2(NUM_TERMS);
   localparam int LEAVES    = 1 << LEVELS;

   // Heap-ordered tree: node 0 is the root, leaves start at LEAVES-1.
   logic signed [SUM_W-1:0] node [0:2*LEAVES-2];

   genvar k;
   generate
      for (k = 0; k < LEAVES; k++) begin : g_leaf
         if (k == 0) begin : g_bias
            assign node[LEAVES-1] = SUM_W'(signed'(weights[0]));
         end else if (k < NUM_TERMS) begin : g_term
            logic signed [SUM_W-1:0] w_ext;
            assign w_ext = SUM_W'(signed'(weights[k]));
            // A taken history bit adds the weight, a not-taken bit subtracts it.
            assign node[LEAVES-1+k] = hist_bits[k-1] ? w_ext : -w_ext;
         end else begin : g_pad
            assign node[LEAVES-1+k] = '0;
         end
      end
      for (k = 0; k < LEAVES - 1; k++) begin : g_add
         assign node[k] = node[2*k+1] + node[2*k+2];
      end
   endgenerate

   assign sum = node[0];

endmodule

>>> hw/rtl/pbp_weights.sv
`timescale 1ns / 1ps

module pbp_weights
   import pbp_pkg::*;
#(
   parameter int HIST_LEN    = HIST_LEN_DEFAULT,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  train_ctl_type                      train_ctl,
   input  logic [HIST_LEN-1:0]                hist_bits,
   output logic [HIST_LEN:0][WEIGHT_BITS-1:0] weights
);

   localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
   localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

   logic [HIST_LEN:0][WEIGHT_BITS-1:0] weights_ff;
   logic [HIST_LEN:0][WEIGHT_BITS-1:0] weights_in;
   logic [HIST_LEN:0]                  step_up;

   // The bias follows the outcome; a history weight steps up when its bit
   // agrees with the outcome and down otherwise.
   assign step_up[0] = train_ctl.actual_taken;

   genvar k;
   generate
      for (k = 1; k <= HIST_LEN; k++) begin : g_dir
         assign step_up[k] = (hist_bits[k-1] == train_ctl.actual_taken);
      end
   endgenerate

   always_comb begin
      logic signed [WEIGHT_BITS-1:0] w;
      weights_in = weights_ff;
      for (int i = 0; i <= HIST_LEN; i++) begin
         w = signed'(weights_ff[i]);
         if (train_ctl.enable) begin
            if (step_up[i]) begin
               weights_in[i] = (w != W_MAX) ? WEIGHT_BITS'(w + 1) : w;
            end else begin
               weights_in[i] = (w != W_MIN) ? WEIGHT_BITS'(w - 1) : w;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff <= '0;
      end else begin
         weights_ff <= weights_in;
      end
   end

   assign weights = weights_ff;

endmodule

>>> hw/rtl/perceptron_branch_predictor.sv
`timescale 1ns / 1ps

// Single-perceptron branch predictor. A predict item carries a global
// history word; the block adds the bias weight and, for each history bit,
// adds or subtracts the matching weight, returns the sum and a taken flag
// (sum not negative), and keeps the sum's magnitude for the next training
// decision. A train item carries the history, the earlier prediction and
// the real outcome; the weights step toward the outcome, saturating at the
// signed weight range, when the prediction was wrong or the kept magnitude
// is below the threshold written through the csr port (reset value 44).
// Every item gives exactly one result item. The block accepts one item per
// clock cycle while the result side is ready. An accepted item is held in
// the input register and then moves into the result register, from which
// its result is offered. The weight adder tree and the training update
// both sit between the input register and the result register, so an item
// always sees the weights left by the item before it. The user must write
// the threshold only while no item is in flight; the block itself does not
// enforce this.

module perceptron_branch_predictor
   import pbp_pkg::*;
#(
   parameter int HIST_LEN    = HIST_LEN_DEFAULT,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   pbp_req_if.sink             req_chan,
   pbp_rsp_if.source           rsp_chan,
   input  logic                csr_wr_en,
   input  logic [THRESH_W-1:0] csr_wr_data
);

   // Wide enough that the sum of all weights at their extremes, and its
   // magnitude, never wrap.
   localparam int SUM_W  = WEIGHT_BITS + $clog2(HIST_LEN + 2);
   localparam int DEXT_W = (SUM_W > DOT_W) ? SUM_W : DOT_W;
   localparam int MEXT_W = (SUM_W > MAG_W) ? SUM_W : MAG_W;

   // Input register stage.
   logic                s1_valid_ff, s1_valid_in;
   func_type            s1_func_ff;
   logic [HIST_W-1:0]   s1_history_ff;
   logic                s1_pred_ff;
   logic                s1_act_ff;

   // Result register stage.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_taken_ff;
   logic [DOT_W-1:0]    rsp_dot_ff;
   logic                rsp_trained_ff;

   // Architectural state.
   logic [THRESH_W-1:0] threshold_ff, threshold_in;
   logic [MAG_W-1:0]    last_mag_ff, last_mag_in;

   logic                req_take;
   logic                advance;
   logic [HIST_LEN-1:0] hist_bits;
   logic [HIST_LEN:0][WEIGHT_BITS-1:0] weights;
   logic signed [SUM_W-1:0]  sum;
   logic signed [DEXT_W-1:0] sum_ext;
   logic [SUM_W-1:0]         sum_abs;
   logic [MEXT_W-1:0]        mag_ext;
   logic [MAG_W-1:0]         mag_sat;
   logic                     do_train;
   train_ctl_type            train_ctl;

   // The item in the input register moves on whenever the result register
   // is empty or is being emptied in this cycle; the input register takes a
   // new item whenever it is empty or its item moves on.
   assign advance          = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !s1_valid_ff || advance;
   assign req_take         = req_chan.valid && req_chan.ready;

   // History bits beyond the 16-bit field read as not taken.
   genvar k;
   generate
      for (k = 0; k < HIST_LEN; k++) begin : g_hist
         if (k < HIST_W) begin : g_in
            assign hist_bits[k] = s1_history_ff[k];
         end else begin : g_zero
            assign hist_bits[k] = 1'b0;
         end
      end
   endgenerate

   pbp_dot_tree #(
      .HIST_LEN    (HIST_LEN),
      .WEIGHT_BITS (WEIGHT_BITS),
      .SUM_W       (SUM_W)
   ) u_dot_tree (
      .weights   (weights),
      .hist_bits (hist_bits),
      .sum       (sum)
   );

   // The reported sum is the low bits of the full sum; the kept magnitude
   // saturates at its all-ones value.
   assign sum_ext = DEXT_W'(sum);
   assign sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
   assign mag_ext = MEXT_W'(sum_abs);
   assign mag_sat = (mag_ext > MEXT_W'(MAG_MAX)) ? MAG_MAX : mag_ext[MAG_W-1:0];

   // A wrong prediction always trains; otherwise training happens only
   // while the last prediction was not confident enough.
   assign do_train = (s1_pred_ff != s1_act_ff) || (last_mag_ff < threshold_ff);

   assign train_ctl.enable       = advance && (s1_func_ff == FUNC_TRAIN) && do_train;
   assign train_ctl.actual_taken = s1_act_ff;

   pbp_weights #(
      .HIST_LEN    (HIST_LEN),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_weights (
      .clock     (clock),
      .reset     (reset),
      .train_ctl (train_ctl),
      .hist_bits (hist_bits),
      .weights   (weights)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      threshold_in = csr_wr_en ? csr_wr_data : threshold_ff;

      last_mag_in = last_mag_ff;
      if (advance && (s1_func_ff == FUNC_PREDICT)) begin
         last_mag_in = mag_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         threshold_ff <= THRESH_RESET;
         last_mag_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         threshold_ff <= threshold_in;
         last_mag_ff  <= last_mag_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff    <= req_chan.func;
         s1_history_ff <= req_chan.history;
         s1_pred_ff    <= req_chan.predicted_taken;
         s1_act_ff     <= req_chan.actual_taken;
      end
      if (advance) begin
         case (s1_func_ff)
            FUNC_PREDICT: begin
               rsp_taken_ff   <= !sum[SUM_W-1];
               rsp_dot_ff     <= sum_ext[DOT_W-1:0];
               rsp_trained_ff <= 1'b0;
            end
            FUNC_TRAIN: begin
               rsp_taken_ff   <= 1'b0;
               rsp_dot_ff     <= '0;
               rsp_trained_ff <= do_train;
            end
            default: begin
               rsp_taken_ff   <= 1'b0;
               rsp_dot_ff     <= '0;
               rsp_trained_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.predict_taken = rsp_taken_ff;
   assign rsp_chan.dot_sum       = signed'(rsp_dot_ff);
   assign rsp_chan.trained       = rsp_trained_ff;

   // An item held in the input register is never dropped while it waits.
   a_s1_hold: assert property (
      @(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff
   ) else $error("input register lost a waiting item");

   // A training result never carries prediction fields.
   a_train_fields: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_trained_ff) |-> (!rsp_taken_ff && (rsp_dot_ff == '0))
   ) else $error("training result carries a nonzero sum or taken flag");

   // Weights change only when a train item that trains moves on.
   a_weights_stable: assert property (
      @(posedge clock) disable iff (reset)
      !train_ctl.enable |=> $stable(weights)
   ) else $error("weights changed without a training item");

   // The kept magnitude changes only when a predict item moves on.
   a_mag_stable: assert property (
      @(posedge clock) disable iff (reset)
      !(advance && (s1_func_ff == FUNC_PREDICT)) |=> $stable(last_mag_ff)
   ) else $error("kept magnitude changed without a predict item");

endmodule
